// ----- rtl/rbb_pkg.sv -----
`timescale 1ns / 1ps
package rbb_pkg;

   localparam int MAX_RADIUS  = 7;
   localparam int MAX_WIDTH   = 1024;
   localparam int STORE_ROWS  = 2 * MAX_RADIUS + 1;
   localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int SLOT_W      = $clog2(STORE_ROWS);
   localparam int ADDR_W      = SLOT_W + COL_W;
   localparam int SPAN_W      = $clog2(2 * MAX_RADIUS + 1);
   localparam int SUM_W       = 16;
   localparam int DIV_W       = 8;
   localparam int STEP_W      = $clog2(SUM_W);

   localparam logic [10:0] WIDTH_LIMIT  = 11'd1024;
   localparam logic [10:0] HEIGHT_LIMIT = 11'd1024;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [1:0] CSR_RADIUS = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;

   typedef struct packed {
      logic       op;
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [9:0] out_x;
      logic [9:0] out_y;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]        radius;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_slot;
      logic [COL_W-1:0]  wr_col;
      logic [23:0]       wr_data;
      logic              rd_en;
      logic              rd_inframe;
      logic [SLOT_W-1:0] rd_slot;
      logic [COL_W-1:0]  rd_col;
      logic              acc_clr;
      logic              div_load;
      logic              div_step;
      logic              out_load;
      logic [9:0]        out_x;
      logic [9:0]        out_y;
      logic              out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      slot_inc = (s == SLOT_W'(STORE_ROWS - 1)) ? '0 : s + 1'b1;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_sub(input logic [SLOT_W-1:0] s,
                                                   input logic [SLOT_W-1:0] k);
      slot_sub = (s >= k) ? s - k : s + SLOT_W'(STORE_ROWS) - k;
   endfunction

endpackage

// ----- rtl/rbb_datapath.sv -----
`timescale 1ns / 1ps
module rbb_datapath import rbb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp
);

   logic [23:0]       store [0:STORE_DEPTH-1];
   logic [23:0]       q_ff;
   logic              v_ff;
   logic [SUM_W-1:0]  acc_ff [3];
   logic [SUM_W-1:0]  quo_ff [3];
   logic [DIV_W-1:0]  rem_ff [3];
   logic [3:0]        side;
   logic [DIV_W-1:0]  divisor;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   assign side    = {cmd.radius, 1'b1};
   assign divisor = DIV_W'(side) * DIV_W'(side);
   assign wr_addr = {cmd.wr_slot, cmd.wr_col};
   assign rd_addr = {cmd.rd_slot, cmd.rd_col};

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         store[wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         q_ff <= store[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= cmd.rd_en & cmd.rd_inframe;
      end
   end

   // One lane per color component; restoring divide, one quotient bit a step.
   always_ff @(posedge clock) begin
      for (int n = 0; n < 3; n++) begin
         logic [DIV_W:0] sh;
         sh = {rem_ff[n], quo_ff[n][SUM_W-1]};
         if (cmd.acc_clr) begin
            acc_ff[n] <= '0;
         end else if (v_ff) begin
            acc_ff[n] <= acc_ff[n] + SUM_W'(q_ff[23-8*n -: 8]);
         end
         if (cmd.div_load) begin
            quo_ff[n] <= acc_ff[n];
            rem_ff[n] <= '0;
         end else if (cmd.div_step) begin
            if (sh >= {1'b0, divisor}) begin
               rem_ff[n] <= DIV_W'(sh - {1'b0, divisor});
               quo_ff[n] <= {quo_ff[n][SUM_W-2:0], 1'b1};
            end else begin
               rem_ff[n] <= sh[DIV_W-1:0];
               quo_ff[n] <= {quo_ff[n][SUM_W-2:0], 1'b0};
            end
         end
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.out_red   <= quo_ff[0][7:0];
         rsp_ff.out_green <= quo_ff[1][7:0];
         rsp_ff.out_blue  <= quo_ff[2][7:0];
         rsp_ff.out_x     <= cmd.out_x;
         rsp_ff.out_y     <= cmd.out_y;
         rsp_ff.run_last  <= cmd.out_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- rtl/rbb_control.sv -----
`timescale 1ns / 1ps
module rbb_control import rbb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req,
   input  logic [2:0]    radius,
   input  logic [10:0]   frame_width,
   input  logic [10:0]   frame_height,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_SETUP, S_WIN, S_WAIT, S_DLOAD, S_DIV, S_PUSH
   } state_type;

   state_type         state_ff, state_in;
   logic [9:0]        icol_ff, icol_in;
   logic [10:0]       irow_ff, irow_in;
   logic [SLOT_W-1:0] islot_ff, islot_in;
   logic [9:0]        ecol_ff, ecol_in;
   logic [10:0]       erow_ff, erow_in;
   logic [SLOT_W-1:0] eslot_ff, eslot_in;
   logic              fd_ff, fd_in;
   logic [9:0]        x_ff, x_in;
   logic [9:0]        xend_ff, xend_in;
   logic [9:0]        y_ff, y_in;
   logic [SLOT_W-1:0] yslot_ff, yslot_in;
   logic [SPAN_W-1:0] k_ff, k_in;
   logic [SPAN_W-1:0] m_ff, m_in;
   logic [11:0]       j_ff, j_in;
   logic [11:0]       i_ff, i_in;
   logic [SLOT_W-1:0] jslot_ff, jslot_in;
   logic [STEP_W-1:0] d_ff, d_in;

   logic [10:0]       w_eff, h_eff;
   logic [10:0]       ec, er, c, yi, y, x0, x1;
   logic [SLOT_W-1:0] es, ys, yslot;
   logic [SLOT_W-1:0] nb;
   logic [SPAN_W-1:0] span;
   logic              fd_t, row_end, have;

   always_comb begin
      w_eff = (frame_width == '0) ? 11'd1 :
              (frame_width > WIDTH_LIMIT) ? WIDTH_LIMIT : frame_width;
      h_eff = (frame_height == '0) ? 11'd1 :
              (frame_height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : frame_height;
      span  = {radius, 1'b0};

      state_in = state_ff;
      icol_in  = icol_ff;   irow_in  = irow_ff;   islot_in = islot_ff;
      ecol_in  = ecol_ff;   erow_in  = erow_ff;   eslot_in = eslot_ff;
      fd_in    = fd_ff;
      x_in     = x_ff;      xend_in  = xend_ff;
      y_in     = y_ff;      yslot_in = yslot_ff;
      k_in     = k_ff;      m_in     = m_ff;
      j_in     = j_ff;      i_in     = i_ff;      jslot_in = jslot_ff;
      d_in     = d_ff;
      ec = '0; er = '0; es = '0; c = '0; yi = '0; ys = '0; y = '0;
      x0 = '0; x1 = '0; yslot = '0; nb = '0; fd_t = 1'b0;
      row_end = 1'b0; have = 1'b0;

      cmd        = '0;
      cmd.radius = radius;
      req_stall  = (state_ff != S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req.op == OP_DRAIN) begin
                  if (fd_ff) begin
                     ec = {1'b0, ecol_ff}; er = erow_ff; es = eslot_ff;
                     if (ec >= w_eff) begin
                        ec = '0; er = er + 1'b1; es = slot_inc(es);
                     end
                     if (er >= h_eff) begin
                        fd_in = 1'b0; ecol_in = '0; erow_in = '0; eslot_in = '0;
                     end else begin
                        x_in = ec[9:0]; xend_in = ec[9:0];
                        y_in = er[9:0]; yslot_in = es;
                        state_in = S_SETUP;
                        ec = ec + 1'b1;
                        if (ec >= w_eff) begin
                           ec = '0; er = er + 1'b1; es = slot_inc(es);
                        end
                        if (er >= h_eff) begin
                           fd_in = 1'b0; ec = '0; er = '0; es = '0;
                        end
                        ecol_in = ec[9:0]; erow_in = er; eslot_in = es;
                     end
                  end
               end else begin
                  fd_t = fd_ff; ec = {1'b0, ecol_ff}; er = erow_ff; es = eslot_ff;
                  if (fd_t) begin
                     fd_t = 1'b0; ec = '0; er = '0; es = '0;
                  end
                  c = {1'b0, icol_ff}; yi = irow_ff; ys = islot_ff;
                  if (c >= w_eff) begin
                     c = '0; yi = yi + 1'b1; ys = slot_inc(ys);
                  end
                  if (yi >= h_eff) begin
                     yi = '0; ys = '0;
                  end
                  cmd.wr_en   = 1'b1;
                  cmd.wr_slot = ys;
                  cmd.wr_col  = c[9:0];
                  cmd.wr_data = {req.in_red, req.in_green, req.in_blue};
                  row_end = (c == w_eff - 1'b1);
                  if (yi >= {8'b0, radius}) begin
                     y     = yi - {8'b0, radius};
                     yslot = slot_sub(ys, {1'b0, radius});
                     if (row_end) begin
                        x0 = (c >= {8'b0, radius}) ? c - {8'b0, radius} : '0;
                        x1 = w_eff - 1'b1;
                        have = 1'b1;
                     end else if (c >= {8'b0, radius}) begin
                        x0 = c - {8'b0, radius};
                        x1 = x0;
                        have = 1'b1;
                     end
                     if (have) begin
                        x_in = x0[9:0]; xend_in = x1[9:0];
                        y_in = y[9:0]; yslot_in = yslot;
                        state_in = S_SETUP;
                        if (row_end) begin
                           ec = '0; er = y + 1'b1; es = slot_inc(yslot);
                        end else begin
                           ec = x1 + 1'b1; er = y; es = yslot;
                        end
                     end
                  end
                  if (row_end) begin
                     icol_in = '0;
                     if (yi >= h_eff - 1'b1) begin
                        irow_in = '0; islot_in = '0;
                        nb = (h_eff < {8'b0, radius}) ? h_eff[SLOT_W-1:0] : {1'b0, radius};
                        if (nb != '0) begin
                           fd_t = 1'b1; ec = '0;
                           er = h_eff - {7'b0, nb};
                           es = slot_sub(slot_inc(ys), nb);
                        end else begin
                           ec = '0; er = '0; es = '0;
                        end
                     end else begin
                        irow_in = yi + 1'b1; islot_in = slot_inc(ys);
                     end
                  end else begin
                     icol_in = c[9:0] + 1'b1; irow_in = yi; islot_in = ys;
                  end
                  fd_in = fd_t; ecol_in = ec[9:0]; erow_in = er; eslot_in = es;
               end
            end
         end
         S_SETUP: begin
            cmd.acc_clr = 1'b1;
            k_in = '0; m_in = '0;
            j_in = 12'(y_ff) - 12'(radius);
            i_in = 12'(x_ff) - 12'(radius);
            jslot_in = slot_sub(yslot_ff, {1'b0, radius});
            state_in = S_WIN;
         end
         S_WIN: begin
            cmd.rd_en      = 1'b1;
            cmd.rd_inframe = !j_ff[11] && (j_ff[10:0] < h_eff) &&
                             !i_ff[11] && (i_ff[10:0] < w_eff);
            cmd.rd_slot    = jslot_ff;
            cmd.rd_col     = i_ff[9:0];
            if (m_ff == span) begin
               m_in = '0;
               i_in = 12'(x_ff) - 12'(radius);
               if (k_ff == span) begin
                  state_in = S_WAIT;
               end else begin
                  k_in = k_ff + 1'b1;
                  j_in = j_ff + 1'b1;
                  jslot_in = slot_inc(jslot_ff);
               end
            end else begin
               m_in = m_ff + 1'b1;
               i_in = i_ff + 1'b1;
            end
         end
         S_WAIT: begin
            state_in = S_DLOAD;
         end
         S_DLOAD: begin
            cmd.div_load = 1'b1;
            d_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (d_ff == STEP_W'(SUM_W - 1)) begin
               state_in = S_PUSH;
            end else begin
               d_in = d_ff + 1'b1;
            end
         end
         S_PUSH: begin
            cmd.out_x    = x_ff;
            cmd.out_y    = y_ff;
            cmd.out_last = (x_ff == xend_ff);
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (x_ff == xend_ff) begin
                  state_in = S_IDLE;
               end else begin
                  x_in = x_ff + 1'b1;
                  state_in = S_SETUP;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         icol_ff  <= '0;  irow_ff  <= '0;  islot_ff <= '0;
         ecol_ff  <= '0;  erow_ff  <= '0;  eslot_ff <= '0;
         fd_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         icol_ff  <= icol_in;  irow_ff  <= irow_in;  islot_ff <= islot_in;
         ecol_ff  <= ecol_in;  erow_ff  <= erow_in;  eslot_ff <= eslot_in;
         fd_ff    <= fd_in;
      end
      x_ff     <= x_in;   xend_ff  <= xend_in;
      y_ff     <= y_in;   yslot_ff <= yslot_in;
      k_ff     <= k_in;   m_ff     <= m_in;
      j_ff     <= j_in;   i_ff     <= i_in;   jslot_ff <= jslot_in;
      d_ff     <= d_in;
   end

endmodule

// ----- rtl/rgb_box_blur.sv -----
`timescale 1ns / 1ps
// Streaming box blur of an RGB frame, pixels in raster order.
// Request channel (req_valid / req_stall / req): op selects a pixel or a
// drain transaction. Each pixel is written to a 15-row line store; once the
// window of an output is complete its mean is emitted on the response
// channel (rsp_valid / rsp_stall / rsp). The pixel that closes a row emits
// the rest of that row, up to radius+1 transactions, run_last on the final one.
// After a frame ends, each drain transaction emits one bottom-border pixel.
// For each output pixel the window is read from the single-read-port line
// store one pixel per cycle, then a 16-step restoring divider forms the three
// means. A transaction that yields no output does not raise req_stall. One
// request is in work at a time; req_stall is high from its
// acceptance until its last output sits in the response register, so the
// next request can be taken while that output is still stalled.
// Reset (synchronous, active high) restores radius 1, 640x480 and clears the
// position counters; the line store is not cleared, and no clearing pass runs.
// A stalled response holds its register; the block pauses before pushing the
// next output.
module rgb_box_blur import rbb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata
);

   logic [2:0]    radius_ff;
   logic [10:0]   width_ff;
   logic [10:0]   height_ff;
   dp_cmd_type    cmd;
   dp_status_type status;

   // Configuration registers; writes to an unused index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 3'd1;
         width_ff  <= 11'd640;
         height_ff <= 11'd480;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RADIUS: radius_ff <= csr_wdata[2:0];
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   rbb_control u_control (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req          (req),
      .radius       (radius_ff),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .status       (status),
      .cmd          (cmd)
   );

   rbb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   // Never overwrite a response that is still waiting to be taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("response register overwritten");

   // A response that is not the last of its transaction means work is open.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp.run_last) |-> req_stall)
      else $error("request taken while a run is incomplete");

   // No response right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

// ----- tb/rgb_box_blur_test.sv -----
`timescale 1ns / 1ps
module rgb_box_blur_test;
   import rbb_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_RADIUS;
   logic [10:0] csr_wdata = '0;

   rgb_box_blur i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req(req),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Shadow of the block: line store, counters and register copies.
   logic [23:0] row_mem [STORE_ROWS][MAX_WIDTH];
   int          blur_r = 1, blur_w = 640, blur_h = 480;
   int          pix_col, pix_row, out_col, out_row;
   bit          border_pending;

   req_type     pixel_queue[$];     // transactions still to be offered
   rsp_type     expected_pixels[$]; // predicted outputs, oldest first
   int          errors = 0;
   bit          quiet_phase = 0;    // no idling near the end
   bit          hold_rsp = 0;       // long receiver hold-off in progress

   function automatic rsp_type window_mean(int x, int y);
      int sr, sg, sb, dv;
      rsp_type o;
      sr = 0; sg = 0; sb = 0;
      dv = (2 * blur_r + 1) * (2 * blur_r + 1);
      for (int j = y - blur_r; j <= y + blur_r; j++) begin
         if (j < 0 || j >= blur_h) continue;
         for (int i = x - blur_r; i <= x + blur_r; i++) begin
            if (i < 0 || i >= blur_w) continue;
            sr += row_mem[j % STORE_ROWS][i][23:16];
            sg += row_mem[j % STORE_ROWS][i][15:8];
            sb += row_mem[j % STORE_ROWS][i][7:0];
         end
      end
      o.out_red = 8'(sr / dv);
      o.out_green = 8'(sg / dv);
      o.out_blue = 8'(sb / dv);
      o.out_x = 10'(x);
      o.out_y = 10'(y);
      o.run_last = 1'b0;
      return o;
   endfunction

   task automatic predict_blur(req_type t);
      rsp_type o;
      int c, yi, y, x0, x1;
      if (t.op == OP_DRAIN) begin
         if (!border_pending) return;
         if (out_col >= blur_w) begin out_col = 0; out_row++; end
         if (out_row >= blur_h) begin
            border_pending = 0; out_col = 0; out_row = 0;
            return;
         end
         o = window_mean(out_col, out_row);
         o.run_last = 1'b1;
         expected_pixels.push_back(o);
         out_col++;
         if (out_col >= blur_w) begin out_col = 0; out_row++; end
         if (out_row >= blur_h) begin border_pending = 0; out_col = 0; out_row = 0; end
         return;
      end
      if (border_pending) begin border_pending = 0; out_col = 0; out_row = 0; end
      if (pix_col >= blur_w) begin pix_col = 0; pix_row++; end
      if (pix_row >= blur_h) pix_row = 0;
      c = pix_col; yi = pix_row;
      row_mem[yi % STORE_ROWS][c] = {t.in_red, t.in_green, t.in_blue};
      if (yi >= blur_r) begin
         y = yi - blur_r;
         if (c == blur_w - 1) begin x0 = (c >= blur_r) ? c - blur_r : 0; x1 = blur_w - 1; end
         else if (c >= blur_r) begin x0 = c - blur_r; x1 = x0; end
         else begin x0 = 1; x1 = 0; end
         for (int x = x0; x <= x1; x++) begin
            o = window_mean(x, y);
            o.run_last = (x == x1);
            expected_pixels.push_back(o);
         end
         if (x1 >= x0) begin
            if (x1 + 1 >= blur_w) begin out_col = 0; out_row = y + 1; end
            else begin out_col = x1 + 1; out_row = y; end
         end
      end
      if (c == blur_w - 1) begin
         pix_col = 0;
         if (yi >= blur_h - 1) begin
            pix_row = 0;
            out_col = 0;
            if (blur_r > 0) begin
               border_pending = 1;
               out_row = blur_h - ((blur_r < blur_h) ? blur_r : blur_h);
            end else begin
               out_row = 0;
            end
         end else begin
            pix_row = yi + 1;
         end
      end else begin
         pix_col = c + 1;
      end
   endtask

   // Driver: offer queued transactions, idle in random bursts.
   int gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_blur(req);
            void'(pixel_queue.pop_front());
         end
         if (req_valid && req_stall) begin
            // hold the stalled payload
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            gap_left <= $urandom_range(0, 6);
            req_valid <= 1'b0;
         end else if (pixel_queue.size() > 0) begin
            req_valid <= 1'b1;
            req <= pixel_queue[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check each response transaction, stall in random bursts.
   int stall_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t unexpected output: actual %p", $time, rsp);
               errors++;
            end else begin
               if (rsp !== expected_pixels[0]) begin
                  $display("%0t mismatch: expected %p actual %p",
                           $time, expected_pixels[0], rsp);
                  errors++;
               end
               void'(expected_pixels.pop_front());
            end
         end
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 6);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, int val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 11'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_RADIUS: blur_r = (val & 7) > MAX_RADIUS ? MAX_RADIUS : (val & 7);
         CSR_WIDTH:  blur_w = (val < 1) ? 1 : (val > 1024 ? 1024 : val);
         default:    blur_h = (val < 1) ? 1 : (val > 1024 ? 1024 : val);
      endcase
   endtask

   // Advance until every queued transaction is taken and all outputs seen.
   task automatic settle();
      while (pixel_queue.size() > 0 || req_valid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic req_type rand_pixel();
      req_type t;
      t.op = OP_PIXEL;
      t.in_red = 8'($urandom);
      t.in_green = 8'($urandom);
      t.in_blue = 8'($urandom);
      return t;
   endfunction

   // Queue whole frames of random pixels, drains, and some noise.
   task automatic queue_frames(int frames);
      req_type t;
      for (int f = 0; f < frames; f++) begin
         for (int p = 0; p < blur_w * blur_h; p++) begin
            t = rand_pixel();
            if ($urandom_range(0, 19) == 0) begin
               t.op = OP_DRAIN;
               pixel_queue.push_back(t);
               t = rand_pixel();
            end
            pixel_queue.push_back(t);
         end
         for (int d = 0; d < blur_w * blur_r + $urandom_range(0, 2); d++) begin
            t = rand_pixel();
            t.op = OP_DRAIN;
            pixel_queue.push_back(t);
         end
      end
   endtask

   task automatic new_setting(int r, int w, int h);
      write_reg(CSR_RADIUS, r);
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
   endtask

   initial begin
      req_type t;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes of components, drain with nothing pending,
      // radius zero, radius larger than the frame, single-pixel frame.
      new_setting(1, 3, 3);
      t = '0; t.op = OP_DRAIN; pixel_queue.push_back(t);
      t = '0; pixel_queue.push_back(t);
      t = '1; t.op = OP_PIXEL; pixel_queue.push_back(t);
      for (int i = 0; i < 7; i++) begin
         t = (i % 2) ? '1 : '0;
         t.op = OP_PIXEL;
         pixel_queue.push_back(t);
      end
      t = '1; pixel_queue.push_back(t);   // one drain: first bottom-border pixel
      t = '0; t.op = OP_PIXEL; pixel_queue.push_back(t); // drops the rest
      // finish that frame and drain its bottom row
      for (int i = 0; i < 8; i++) begin
         t = (i % 3) ? '1 : '0;
         t.op = OP_PIXEL;
         pixel_queue.push_back(t);
      end
      for (int i = 0; i < 3; i++) begin
         t = '0; t.op = OP_DRAIN; pixel_queue.push_back(t);
      end
      settle();
      new_setting(0, 2, 2);
      queue_frames(1);
      settle();
      new_setting(7, 1, 1);
      queue_frames(2);
      settle();
      new_setting(7, 3, 2);
      queue_frames(1);
      settle();

      // Long receiver hold-off while the sender keeps offering.
      new_setting(2, 5, 4);
      queue_frames(1);
      hold_rsp = 1;
      repeat (200) @(posedge clock);
      hold_rsp = 0;
      settle();

      new_setting(3, 9, 5);
      queue_frames(1);
      settle();
      new_setting(1, 20, 1);
      queue_frames(1);
      settle();
      new_setting(5, 7, 3);
      quiet_phase = 1;
      queue_frames(1);
      settle();

      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/rbb_pkg.sv
rtl/rbb_datapath.sv
rtl/rbb_control.sv
rtl/rgb_box_blur.sv
tb/rgb_box_blur_test.sv
